// ----- rtl/rpt_pkg.sv -----
// Package for the rectangle perimeter tracker: widths, codes and shared types.
`timescale 1ns / 1ps
package rpt_pkg;

  localparam int unsigned COORD_W = 32;  // signed Q16.16 coordinates and speed
  localparam int unsigned LEN_W   = 31;  // width and height
  localparam int unsigned POS_W   = 33;  // perimeter distance and reported positions
  localparam int unsigned SF_W    = 18;  // start fraction, Q2.16
  localparam int unsigned TIME_W  = 32;  // elapsed time
  localparam int unsigned PROD_W  = 64;  // product of the shared multiplier
  localparam int unsigned STEP_W  = 48;  // product rounded to Q32.16
  localparam int unsigned DVD_W   = 49;  // dividend of the remainder unit
  localparam int unsigned IDX_W   = 3;   // register index
  localparam int unsigned DATA_W  = 32;  // register write data
  localparam int unsigned SIDE_W  = 2;

  localparam logic [PROD_W-1:0]  ROUND_BIAS = 64'h0000_0000_0000_FFFF;
  localparam logic [COORD_W-1:0] SPEED_MIN  = 32'h8000_0000;
  localparam logic [COORD_W-1:0] SPEED_MAX  = 32'h7FFF_FFFF;

  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_AREA_MIN_X     = 3'd0,
    REG_AREA_MIN_Y     = 3'd1,
    REG_AREA_WIDTH     = 3'd2,
    REG_AREA_HEIGHT    = 3'd3,
    REG_SPEED          = 3'd4,
    REG_START_FRACTION = 3'd5
  } cfg_reg_e;

  typedef enum logic [SIDE_W-1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_BOTTOM = 2'd2,
    SIDE_LEFT   = 2'd3
  } side_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_LOAD,
    ST_REM,
    ST_WRAP,
    ST_SIDE,
    ST_OUT
  } state_e;

  // Status returned by the remainder unit.
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] rem;
  } rem_stat_t;

endpackage

// ----- rtl/rpt_if.sv -----
// Handshake interfaces for the input, result and register write channels.
`timescale 1ns / 1ps
interface rpt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [rpt_pkg::TIME_W-1:0] elapsed_time;

  modport source (output valid, output kind, output elapsed_time, input ready);
  modport sink   (input valid, input kind, input elapsed_time, output ready);
endinterface

interface rpt_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rpt_pkg::POS_W-1:0]   pos_x;
  logic signed [rpt_pkg::POS_W-1:0]   pos_y;
  logic signed [rpt_pkg::COORD_W-1:0] vel_x;
  logic signed [rpt_pkg::COORD_W-1:0] vel_y;
  logic        [rpt_pkg::SIDE_W-1:0]  side;
  logic        [rpt_pkg::POS_W-1:0]   perimeter_pos;

  modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                  output side, output perimeter_pos, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                  input side, input perimeter_pos, output ready);
endinterface

interface rpt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rpt_pkg::IDX_W-1:0]  index;
  logic [rpt_pkg::DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rpt_rem.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module rpt_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rpt_pkg::DVD_W-1:0]   dividend_i,
  input  logic [rpt_pkg::POS_W-1:0]   divisor_i,
  output rpt_pkg::rem_stat_t          stat_o
);

  localparam int unsigned CNT_W = $clog2(rpt_pkg::DVD_W);

  logic [rpt_pkg::DVD_W-1:0] dvd_q;
  logic [rpt_pkg::POS_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [rpt_pkg::POS_W:0]   trial;

  // The partial remainder stays below the divisor, so one compare and
  // subtract per bit keeps it reduced.
  always_comb begin
    trial = {rem_q, dvd_q[rpt_pkg::DVD_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_d = rpt_pkg::POS_W'(trial - {1'b0, divisor_i});
    end else begin
      rem_d = trial[rpt_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(rpt_pkg::DVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[rpt_pkg::DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;

endmodule

// ----- rtl/rectangle_perimeter_tracker.sv -----
// Top level: tracks a point moving around the edge of a rectangle.
// A restart word passes through the MUL, STEP, SIDE and OUT states; an advance word
// also passes LOAD, REM and WRAP, where the bit-serial remainder by the perimeter runs,
// unless the perimeter is zero. A new word is taken only in IDLE, once the previous
// word is through; a word may be accepted while the previous result waits.
// rst_ni clears the registers, the distance travelled and the result valid flag.
`timescale 1ns / 1ps
module rectangle_perimeter_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpt_in_if.sink      in_i,
  rpt_out_if.source   out_o,
  rpt_cfg_if.sink     cfg_i
);

  // Configuration registers
  logic [rpt_pkg::COORD_W-1:0] min_x_q, min_y_q, speed_q;
  logic [rpt_pkg::LEN_W-1:0]   w_q, h_q;
  logic [rpt_pkg::SF_W-1:0]    sf_q;

  rpt_pkg::state_e             state_q, state_d;
  logic [rpt_pkg::POS_W-1:0]   travel_q;
  logic                        kind_q;
  logic [rpt_pkg::TIME_W-1:0]  el_q;
  logic [rpt_pkg::PROD_W-1:0]  prod_q;
  logic [rpt_pkg::STEP_W-1:0]  step_q;
  logic                        neg_wrap_q;
  rpt_pkg::side_e              side_q, side_d;
  logic [rpt_pkg::POS_W-1:0]   off_q, off_d;

  logic                        out_valid_q;
  logic [rpt_pkg::POS_W-1:0]   px_q, py_q, px_d, py_d;
  logic [rpt_pkg::COORD_W-1:0] vx_q, vy_q, vx_d, vy_d;
  logic [rpt_pkg::SIDE_W-1:0]  sd_q;
  logic [rpt_pkg::POS_W-1:0]   pp_q;

  logic [rpt_pkg::POS_W-1:0]   c1, c2, c3, per, corner;
  logic [rpt_pkg::LEN_W-1:0]   len;
  logic                        per_zero;
  logic [rpt_pkg::POS_W-1:0]   restart_sum;
  logic [rpt_pkg::COORD_W-1:0] mag, neg_speed, mul_a, mul_b;
  logic [rpt_pkg::PROD_W-1:0]  round_sum;
  logic [rpt_pkg::DVD_W-1:0]   t_ext, s_ext, dividend;
  logic                        neg_wrap_d;
  logic [rpt_pkg::POS_W-1:0]   mx, my, wx, hx;
  logic                        in_acc, cfg_acc, out_load, rem_start;
  rpt_pkg::rem_stat_t          rem_stat;

  assign in_acc  = in_i.valid && in_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  // Corners and perimeter
  assign c1       = rpt_pkg::POS_W'(w_q);
  assign c2       = rpt_pkg::POS_W'(w_q) + rpt_pkg::POS_W'(h_q);
  assign c3       = c2 + c1;
  assign per      = {c2[rpt_pkg::POS_W-2:0], 1'b0};
  assign per_zero = (per == '0);

  always_comb begin
    case (rpt_pkg::side_e'(sf_q[rpt_pkg::SF_W-1 -: rpt_pkg::SIDE_W]))
      rpt_pkg::SIDE_TOP:    begin corner = '0; len = w_q; end
      rpt_pkg::SIDE_RIGHT:  begin corner = c1; len = h_q; end
      rpt_pkg::SIDE_BOTTOM: begin corner = c2; len = w_q; end
      rpt_pkg::SIDE_LEFT:   begin corner = c3; len = h_q; end
      default:              begin corner = '0; len = w_q; end
    endcase
  end

  // Shared multiplier operands: fraction times side length on restart,
  // speed magnitude times elapsed time on advance.
  assign mag       = speed_q[rpt_pkg::COORD_W-1] ? (~speed_q + 1'b1) : speed_q;
  assign neg_speed = (speed_q == rpt_pkg::SPEED_MIN) ? rpt_pkg::SPEED_MAX
                                                     : (~speed_q + 1'b1);
  assign mul_a = (kind_q == rpt_pkg::KIND_RESTART)
                 ? rpt_pkg::COORD_W'(sf_q[15:0]) : mag;
  assign mul_b = (kind_q == rpt_pkg::KIND_RESTART)
                 ? rpt_pkg::COORD_W'(len) : el_q;

  // A left-side start on a rectangle of zero height lands on the perimeter
  // itself, which wraps to the top-left corner.
  assign restart_sum = corner + rpt_pkg::POS_W'(prod_q[46:16]);

  // A negative step is rounded towards minus infinity, i.e. its magnitude up.
  assign round_sum = prod_q + (speed_q[rpt_pkg::COORD_W-1] ? rpt_pkg::ROUND_BIAS : '0);

  // The wrap is done on travel plus or minus the step in one remainder pass;
  // a negative difference is remaindered by magnitude and reflected after.
  always_comb begin
    t_ext      = rpt_pkg::DVD_W'(travel_q);
    s_ext      = rpt_pkg::DVD_W'(step_q);
    neg_wrap_d = 1'b0;
    if (!speed_q[rpt_pkg::COORD_W-1]) begin
      dividend = t_ext + s_ext;
    end else if (s_ext > t_ext) begin
      dividend   = s_ext - t_ext;
      neg_wrap_d = 1'b1;
    end else begin
      dividend = t_ext - s_ext;
    end
  end

  rpt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (dividend),
    .divisor_i  (per),
    .stat_o     (rem_stat)
  );

  // Side selection; a zero-length side is passed over by the order of tests.
  always_comb begin
    if (travel_q < c1) begin
      side_d = rpt_pkg::SIDE_TOP;
      off_d  = travel_q;
    end else if (travel_q < c2) begin
      side_d = rpt_pkg::SIDE_RIGHT;
      off_d  = travel_q - c1;
    end else if (travel_q < c3) begin
      side_d = rpt_pkg::SIDE_BOTTOM;
      off_d  = travel_q - c2;
    end else begin
      side_d = rpt_pkg::SIDE_LEFT;
      off_d  = travel_q - c3;
    end
  end

  // Result word, computed modulo 2^33
  assign mx = {min_x_q[rpt_pkg::COORD_W-1], min_x_q};
  assign my = {min_y_q[rpt_pkg::COORD_W-1], min_y_q};
  assign wx = rpt_pkg::POS_W'(w_q);
  assign hx = rpt_pkg::POS_W'(h_q);

  always_comb begin
    case (side_q)
      rpt_pkg::SIDE_TOP: begin
        px_d = mx + off_q;  py_d = my;
        vx_d = speed_q;     vy_d = '0;
      end
      rpt_pkg::SIDE_RIGHT: begin
        px_d = mx + wx;     py_d = my + off_q;
        vx_d = '0;          vy_d = speed_q;
      end
      rpt_pkg::SIDE_BOTTOM: begin
        px_d = mx + wx - off_q;  py_d = my + hx;
        vx_d = neg_speed;        vy_d = '0;
      end
      rpt_pkg::SIDE_LEFT: begin
        px_d = mx;          py_d = my + hx - off_q;
        vx_d = '0;          vy_d = neg_speed;
      end
      default: begin
        px_d = mx;          py_d = my;
        vx_d = '0;          vy_d = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    rem_start   = 1'b0;
    out_load    = 1'b0;
    in_i.ready  = 1'b0;
    case (state_q)
      rpt_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = rpt_pkg::ST_MUL;
        end
      end
      rpt_pkg::ST_MUL: state_d = rpt_pkg::ST_STEP;
      rpt_pkg::ST_STEP: begin
        if (kind_q == rpt_pkg::KIND_RESTART || per_zero) begin
          state_d = rpt_pkg::ST_SIDE;
        end else begin
          state_d = rpt_pkg::ST_LOAD;
        end
      end
      rpt_pkg::ST_LOAD: begin
        rem_start = 1'b1;
        state_d   = rpt_pkg::ST_REM;
      end
      rpt_pkg::ST_REM: begin
        if (rem_stat.done) begin
          state_d = rpt_pkg::ST_WRAP;
        end
      end
      rpt_pkg::ST_WRAP: state_d = rpt_pkg::ST_SIDE;
      rpt_pkg::ST_SIDE: state_d = rpt_pkg::ST_OUT;
      rpt_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = rpt_pkg::ST_IDLE;
        end
      end
      default: state_d = rpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      w_q     <= '0;
      h_q     <= '0;
      speed_q <= '0;
      sf_q    <= '0;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        rpt_pkg::REG_AREA_MIN_X:     min_x_q <= cfg_i.data;
        rpt_pkg::REG_AREA_MIN_Y:     min_y_q <= cfg_i.data;
        rpt_pkg::REG_AREA_WIDTH:     w_q     <= cfg_i.data[rpt_pkg::LEN_W-1:0];
        rpt_pkg::REG_AREA_HEIGHT:    h_q     <= cfg_i.data[rpt_pkg::LEN_W-1:0];
        rpt_pkg::REG_SPEED:          speed_q <= cfg_i.data;
        rpt_pkg::REG_START_FRACTION: sf_q    <= cfg_i.data[rpt_pkg::SF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      travel_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == rpt_pkg::ST_STEP) begin
        if (kind_q == rpt_pkg::KIND_RESTART) begin
          // The sum never exceeds the perimeter, so one compare and subtract wraps it.
          travel_q <= (restart_sum >= per) ? restart_sum - per : restart_sum;
        end else if (per_zero) begin
          travel_q <= '0;
        end
      end else if (state_q == rpt_pkg::ST_WRAP) begin
        if (neg_wrap_q && rem_stat.rem != '0) begin
          travel_q <= per - rem_stat.rem;
        end else begin
          travel_q <= rem_stat.rem;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= in_i.kind;
      el_q   <= in_i.elapsed_time;
    end
    if (state_q == rpt_pkg::ST_MUL) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == rpt_pkg::ST_STEP) begin
      step_q <= round_sum[rpt_pkg::PROD_W-1 -: rpt_pkg::STEP_W];
    end
    if (state_q == rpt_pkg::ST_LOAD) begin
      neg_wrap_q <= neg_wrap_d;
    end
    if (state_q == rpt_pkg::ST_SIDE) begin
      side_q <= side_d;
      off_q  <= off_d;
    end
    if (out_load) begin
      px_q <= px_d;
      py_q <= py_d;
      vx_q <= vx_d;
      vy_q <= vy_d;
      sd_q <= side_q;
      pp_q <= travel_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pos_x         = px_q;
  assign out_o.pos_y         = py_q;
  assign out_o.vel_x         = vx_q;
  assign out_o.vel_y         = vy_q;
  assign out_o.side          = sd_q;
  assign out_o.perimeter_pos = pp_q;

endmodule

// ----- rtl/rpt_checker.sv -----
// Port-level assertions for the rectangle perimeter tracker, bound to the top level.
`timescale 1ns / 1ps
module rpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [rpt_pkg::POS_W-1:0]   out_pos_x_i,
  input logic [rpt_pkg::POS_W-1:0]   out_pos_y_i,
  input logic [rpt_pkg::COORD_W-1:0] out_vel_x_i,
  input logic [rpt_pkg::COORD_W-1:0] out_vel_y_i,
  input logic [rpt_pkg::SIDE_W-1:0]  out_side_i,
  input logic [rpt_pkg::POS_W-1:0]   out_perimeter_pos_i
);

  // A stalled result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pos_x_i)
      && $stable(out_pos_y_i) && $stable(out_vel_x_i) && $stable(out_vel_y_i)
      && $stable(out_side_i) && $stable(out_perimeter_pos_i))
    else $error("stalled result word changed");

  // A result word is withdrawn only once taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("result word dropped before it was taken");

  // The block works on one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  // Motion is along one axis: horizontal sides carry no y velocity, vertical no x.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_side_i[0] ? (out_vel_x_i == '0) : (out_vel_y_i == '0)))
    else $error("velocity does not match side");

endmodule

bind rectangle_perimeter_tracker rpt_checker u_rpt_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_pos_x_i         (out_o.pos_x),
  .out_pos_y_i         (out_o.pos_y),
  .out_vel_x_i         (out_o.vel_x),
  .out_vel_y_i         (out_o.vel_y),
  .out_side_i          (out_o.side),
  .out_perimeter_pos_i (out_o.perimeter_pos)
);

// ----- tb/rectangle_perimeter_tracker_tb.sv -----
// Testbench for the rectangle perimeter tracker: directed and random words checked by a predictor.
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [rpt_pkg::POS_W-1:0]   pos_x;
  logic signed [rpt_pkg::POS_W-1:0]   pos_y;
  logic signed [rpt_pkg::COORD_W-1:0] vel_x;
  logic signed [rpt_pkg::COORD_W-1:0] vel_y;
  logic        [rpt_pkg::SIDE_W-1:0]  side;
  logic        [rpt_pkg::POS_W-1:0]   perimeter_pos;
} track_result_t;

class perimeter_track_sb;
  logic signed [rpt_pkg::COORD_W-1:0] area_min_x, area_min_y, speed;
  logic        [rpt_pkg::LEN_W-1:0]   area_width, area_height;
  logic        [rpt_pkg::SF_W-1:0]    start_frac;
  logic        [rpt_pkg::POS_W-1:0]   travel;
  track_result_t                      pending_pos[$];
  int unsigned                        errors, checked, restarts, advances;

  function new();
    area_min_x  = '0;
    area_min_y  = '0;
    speed       = '0;
    area_width  = '0;
    area_height = '0;
    start_frac  = '0;
    travel      = '0;
    errors      = 0;
    checked     = 0;
    restarts    = 0;
    advances    = 0;
  endfunction

  task report(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  // Writes to unmapped indexes are dropped by the block.
  function void store_reg(logic [rpt_pkg::IDX_W-1:0] idx, logic [rpt_pkg::DATA_W-1:0] value);
    case (idx)
      rpt_pkg::REG_AREA_MIN_X:     area_min_x  = value;
      rpt_pkg::REG_AREA_MIN_Y:     area_min_y  = value;
      rpt_pkg::REG_AREA_WIDTH:     area_width  = value[rpt_pkg::LEN_W-1:0];
      rpt_pkg::REG_AREA_HEIGHT:    area_height = value[rpt_pkg::LEN_W-1:0];
      rpt_pkg::REG_SPEED:          speed       = value;
      rpt_pkg::REG_START_FRACTION: start_frac  = value[rpt_pkg::SF_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the new distance and the reported position for one accepted word.
  function void take_item(logic kind, logic [rpt_pkg::TIME_W-1:0] elapsed);
    longint signed   min_x, min_y, spd, px, py, vx, vy;
    longint unsigned w, h, c1, c2, c3, per, d, mag, prod, step_len, t, r, len, corner;
    logic [1:0]      s;
    bit              neg;
    track_result_t   exp_r;
    min_x = area_min_x;
    min_y = area_min_y;
    spd   = speed;
    w     = area_width;
    h     = area_height;
    c1    = w;
    c2    = w + h;
    c3    = 2 * w + h;
    per   = 2 * (w + h);
    if (kind == rpt_pkg::KIND_RESTART) begin
      restarts++;
      s = start_frac[17:16];
      case (s)
        rpt_pkg::SIDE_TOP:    corner = 0;
        rpt_pkg::SIDE_RIGHT:  corner = c1;
        rpt_pkg::SIDE_BOTTOM: corner = c2;
        default:              corner = c3;
      endcase
      len = s[0] ? h : w;
      d   = corner + ((longint'(start_frac[15:0]) * len) >> 16);
      d   = (per == 0) ? 0 : d % per;
    end else begin
      advances++;
      if (per == 0) begin
        d = 0;
      end else begin
        // The product is floored, so a negative step rounds its magnitude up.
        neg      = spd < 0;
        mag      = neg ? -spd : spd;
        prod     = mag * longint'(elapsed);
        step_len = neg ? (prod + 64'hFFFF) >> 16 : prod >> 16;
        t        = travel % per;
        r        = step_len % per;
        if (!neg) begin
          d = t + r;
          if (d >= per) d = d - per;
        end else begin
          d = (r <= t) ? t - r : t + per - r;
        end
      end
    end
    travel = d[rpt_pkg::POS_W-1:0];

    if (d < c1) begin
      exp_r.side = rpt_pkg::SIDE_TOP;
      px = min_x + $signed(d);
      py = min_y;
      vx = spd;
      vy = 0;
    end else if (d < c2) begin
      exp_r.side = rpt_pkg::SIDE_RIGHT;
      px = min_x + $signed(w);
      py = min_y + $signed(d - c1);
      vx = 0;
      vy = spd;
    end else if (d < c3) begin
      exp_r.side = rpt_pkg::SIDE_BOTTOM;
      px = min_x + $signed(w) - $signed(d - c2);
      py = min_y + $signed(h);
      vx = (-spd > 64'sd2147483647) ? 64'sd2147483647 : -spd;
      vy = 0;
    end else begin
      exp_r.side = rpt_pkg::SIDE_LEFT;
      px = min_x;
      py = min_y + $signed(h) - $signed(d - c3);
      vx = 0;
      vy = (-spd > 64'sd2147483647) ? 64'sd2147483647 : -spd;
    end
    exp_r.pos_x         = px[rpt_pkg::POS_W-1:0];
    exp_r.pos_y         = py[rpt_pkg::POS_W-1:0];
    exp_r.vel_x         = vx[rpt_pkg::COORD_W-1:0];
    exp_r.vel_y         = vy[rpt_pkg::COORD_W-1:0];
    exp_r.perimeter_pos = d[rpt_pkg::POS_W-1:0];
    pending_pos.push_back(exp_r);
  endfunction

  task check_position(track_result_t got);
    track_result_t want;
    if (pending_pos.size() == 0) begin
      report("result word arrived with nothing outstanding");
    end else begin
      want = pending_pos.pop_front();
      if (got.pos_x !== want.pos_x)
        report($sformatf("word %0d pos_x got %0d want %0d", checked, got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        report($sformatf("word %0d pos_y got %0d want %0d", checked, got.pos_y, want.pos_y));
      if (got.vel_x !== want.vel_x)
        report($sformatf("word %0d vel_x got %0d want %0d", checked, got.vel_x, want.vel_x));
      if (got.vel_y !== want.vel_y)
        report($sformatf("word %0d vel_y got %0d want %0d", checked, got.vel_y, want.vel_y));
      if (got.side !== want.side)
        report($sformatf("word %0d side got %0d want %0d", checked, got.side, want.side));
      if (got.perimeter_pos !== want.perimeter_pos)
        report($sformatf("word %0d perimeter_pos got %0h want %0h", checked,
                         got.perimeter_pos, want.perimeter_pos));
    end
    checked++;
  endtask
endclass

module rectangle_perimeter_tracker_tb;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam logic [rpt_pkg::IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [rpt_pkg::IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   quiet_tail;
  int unsigned settings;

  rpt_in_if  in_if ();
  rpt_out_if out_if ();
  rpt_cfg_if cfg_if ();

  perimeter_track_sb sb = new();
  track_result_t     seen;

  rectangle_perimeter_tracker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Everything is sampled at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.store_reg(cfg_if.index, cfg_if.data);
      if (out_if.valid && out_if.ready) begin
        seen = '{pos_x: out_if.pos_x, pos_y: out_if.pos_y, vel_x: out_if.vel_x,
                 vel_y: out_if.vel_y, side: out_if.side,
                 perimeter_pos: out_if.perimeter_pos};
        sb.check_position(seen);
      end
      if (in_if.valid && in_if.ready) sb.take_item(in_if.kind, in_if.elapsed_time);
    end
  end

  // Result back-pressure in random bursts, released for the quiet tail.
  initial begin
    int unsigned hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet_tail) begin
        out_if.ready = 1'b1;
      end else if (hold != 0) begin
        out_if.ready = 1'b0;
        hold--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_if.ready = 1'b0;
        hold = $urandom_range(0, 15);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return rpt_pkg::SPEED_MIN;
      3:       return rpt_pkg::SPEED_MAX;
      4:       return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge with valid possibly still high.
  task automatic send_item(logic kind, logic [rpt_pkg::TIME_W-1:0] elapsed);
    in_if.valid        = 1'b1;
    in_if.kind         = kind;
    in_if.elapsed_time = elapsed;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    @(negedge clk_i);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.pending_pos.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_reg(logic [rpt_pkg::IDX_W-1:0] idx, logic [rpt_pkg::DATA_W-1:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  initial begin
    int unsigned sent, burst;
    rst_ni             = 1'b0;
    quiet_tail         = 1'b0;
    settings           = 1;
    in_if.valid        = 1'b0;
    in_if.kind         = rpt_pkg::KIND_RESTART;
    in_if.elapsed_time = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = rpt_pkg::REG_AREA_MIN_X;
    cfg_if.data        = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty rectangle out of reset: the point stays on the left side at the origin.
    send_item(rpt_pkg::KIND_RESTART, '0);
    send_item(rpt_pkg::KIND_ADVANCE, 32'hFFFF_FFFF);
    drain();

    // Largest rectangle at the extreme corner, most negative speed so the
    // negated velocity saturates; the upper data bits must be masked off.
    set_reg(rpt_pkg::REG_AREA_MIN_X, rpt_pkg::SPEED_MIN);
    set_reg(rpt_pkg::REG_AREA_MIN_Y, rpt_pkg::SPEED_MAX);
    set_reg(rpt_pkg::REG_AREA_WIDTH, 32'hFFFF_FFFF);
    set_reg(rpt_pkg::REG_AREA_HEIGHT, 32'hFFFF_FFFF);
    set_reg(rpt_pkg::REG_SPEED, rpt_pkg::SPEED_MIN);
    set_reg(rpt_pkg::REG_START_FRACTION, 32'hFFFF_FFFF);
    settings++;
    send_item(rpt_pkg::KIND_RESTART, '0);
    send_item(rpt_pkg::KIND_ADVANCE, '0);
    send_item(rpt_pkg::KIND_ADVANCE, 32'hFFFF_FFFF);
    send_item(rpt_pkg::KIND_ADVANCE, 32'h0000_0001);
    drain();

    set_reg(rpt_pkg::REG_SPEED, rpt_pkg::SPEED_MAX);
    set_reg(rpt_pkg::REG_START_FRACTION, 32'h0001_0000);
    settings++;
    send_item(rpt_pkg::KIND_RESTART, '0);
    send_item(rpt_pkg::KIND_ADVANCE, 32'hFFFF_FFFF);
    send_item(rpt_pkg::KIND_ADVANCE, 32'h0001_0000);
    drain();
    set_reg(rpt_pkg::REG_START_FRACTION, 32'h0002_0000);
    send_item(rpt_pkg::KIND_RESTART, 32'hFFFF_FFFF);
    drain();
    set_reg(rpt_pkg::REG_START_FRACTION, 32'h0002_8000);
    send_item(rpt_pkg::KIND_RESTART, '0);
    drain();

    // Zero width: top and bottom sides are skipped. A tiny negative step
    // must round away from zero.
    set_reg(rpt_pkg::REG_AREA_MIN_X, '0);
    set_reg(rpt_pkg::REG_AREA_MIN_Y, '0);
    set_reg(rpt_pkg::REG_AREA_WIDTH, '0);
    set_reg(rpt_pkg::REG_AREA_HEIGHT, 32'h0010_0000);
    set_reg(rpt_pkg::REG_SPEED, 32'hFFFF_FFFF);
    settings++;
    send_item(rpt_pkg::KIND_RESTART, '0);
    send_item(rpt_pkg::KIND_ADVANCE, 32'h0000_0001);
    send_item(rpt_pkg::KIND_ADVANCE, 32'h0000_8000);
    drain();

    // Zero height, then a smaller perimeter at zero speed.
    set_reg(rpt_pkg::REG_AREA_WIDTH, 32'h0000_0100);
    set_reg(rpt_pkg::REG_AREA_HEIGHT, '0);
    set_reg(rpt_pkg::REG_SPEED, 32'h0001_0000);
    settings++;
    send_item(rpt_pkg::KIND_RESTART, '0);
    send_item(rpt_pkg::KIND_ADVANCE, 32'h0003_0000);
    drain();
    // A left-side start with zero height lands on the perimeter and wraps to 0.
    set_reg(rpt_pkg::REG_START_FRACTION, 32'h0003_4000);
    send_item(rpt_pkg::KIND_RESTART, '0);
    drain();
    set_reg(rpt_pkg::REG_AREA_WIDTH, 32'h0000_0001);
    set_reg(rpt_pkg::REG_AREA_HEIGHT, 32'h0000_0001);
    set_reg(rpt_pkg::REG_SPEED, '0);
    settings++;
    send_item(rpt_pkg::KIND_ADVANCE, 32'h1234_5678);
    drain();

    // Unmapped indexes must leave every register alone.
    set_reg(IDX_UNMAPPED_LO, 32'hFFFF_FFFF);
    set_reg(IDX_UNMAPPED_HI, 32'hFFFF_FFFF);
    send_item(rpt_pkg::KIND_RESTART, '0);
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      set_reg(rpt_pkg::REG_AREA_MIN_X, pick_word());
      set_reg(rpt_pkg::REG_AREA_MIN_Y, pick_word());
      set_reg(rpt_pkg::REG_AREA_WIDTH, pick_word());
      set_reg(rpt_pkg::REG_AREA_HEIGHT, pick_word());
      set_reg(rpt_pkg::REG_SPEED, pick_word());
      set_reg(rpt_pkg::REG_START_FRACTION, $urandom);
      settings++;
      burst = $urandom_range(10, 60);
      for (int unsigned i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        if (sent >= RANDOM_ITEMS * 17 / 20) quiet_tail = 1'b1;
        send_item(($urandom_range(0, 6) == 0) ? rpt_pkg::KIND_RESTART
                                              : rpt_pkg::KIND_ADVANCE, pick_word());
        sent++;
      end
    end
    drain();
    repeat (64) @(posedge clk_i);

    if (sb.pending_pos.size() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending_pos.size()));
    $display("Covered %0d restart and %0d advance words across %0d register settings.",
             sb.restarts, sb.advances, settings);
    $display("Checked %0d result words field by field; %0d mismatches.", sb.checked,
             sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Timed out with %0d result words outstanding.", sb.pending_pos.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
